// ===== rtl/gsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gsc_pkg: shared constants and types of the gradient stop color generator.
// Holds the fixed widths, register indexes and the structs that travel
// alongside items through the arithmetic pipes.
// ----------------------------------------------------------------------------
package gsc_pkg;

    // Coordinate and gradient position formats.
    localparam int COORD_BITS    = 16;
    localparam int POS_FRAC_BITS = 12;
    localparam int RADIUS_W      = 16;

    // Derived widths.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int LEN_W  = PROD_W;
    localparam int RSQ_W  = 2 * RADIUS_W;
    localparam int RAD_W  = RSQ_W + 2 * POS_FRAC_BITS;
    localparam int ROOT_W = RAD_W / 2;
    localparam int POS_W  = POS_FRAC_BITS + 1;

    localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << POS_FRAC_BITS;

    // Configuration port.
    localparam int CFG_W     = 45;
    localparam int IDX_W     = 3;
    localparam int STOP_NUM  = 4;
    localparam logic [2:0] STOP_MAX = 3'd4;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    typedef enum logic [IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_ANCHOR = 3'd1,
        REG_FAR    = 3'd2,
        REG_COUNT  = 3'd3,
        REG_STOP0  = 3'd4,
        REG_STOP1  = 3'd5,
        REG_STOP2  = 3'd6,
        REG_STOP3  = 3'd7
    } cfg_reg_t;

    // How the gradient position of an item is settled.
    typedef enum logic [1:0] {
        T_CALC = 2'd0,
        T_ZERO = 2'd1,
        T_ONE  = 2'd2
    } tcode_t;

    // Sideband carried through the square root pipe.
    typedef struct packed {
        tcode_t             code;
        logic [LEN_W-1:0]   dot;
    } sq_tag_t;

    // Sideband carried through the blend factor divider.
    typedef struct packed {
        logic [31:0] c0;
        logic [31:0] c1;
    } blend_tag_t;

endpackage

// ===== rtl/gsc_pix_if.sv =====
// ----------------------------------------------------------------------------
// gsc_pix_if: pixel coordinate channel.
// Carries one signed pixel coordinate per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsc_pix_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// ===== rtl/gsc_col_if.sv =====
// ----------------------------------------------------------------------------
// gsc_col_if: color channel.
// Carries one RGBA color per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gsc_col_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue,
                    output alpha, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input alpha, output ready);
endinterface

// ===== rtl/gradient_stop_color_generator.sv =====
// ----------------------------------------------------------------------------
// gradient_stop_color_generator: linear or radial multi-stop gradient.
// Maps each pixel coordinate to its gradient color through up to four stops.
//
// Usage:
//   The pix channel takes one pixel coordinate per item, the col channel
//   returns one RGBA color per item, in order. Configuration is written
//   through cfg_we/cfg_index/cfg_data while no item is in flight; the user
//   ensures this, not the block. The block is a single stalling pipeline:
//   one item enters every cycle that it advances, and each item passes 58
//   register stages (4 setup stages, 28 square root stages, 12 position
//   divider stages, one stop select stage, 12 blend factor divider stages,
//   one output stage) before its color is held on col. The square root
//   and the two restoring dividers, one bit per stage, set that depth.
//   When the receiver holds col.ready low with a result waiting, the whole
//   pipeline holds and pix.ready drops; nothing is lost or repeated.
//   Reset clears the configuration and valid registers, emptying the
//   pipeline; with no stops configured the block answers opaque black.
// ----------------------------------------------------------------------------
module gradient_stop_color_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gsc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gsc_pkg::CFG_W-1:0]   cfg_data,
    gsc_pix_if.sink                     pix,
    gsc_col_if.source                   col
);
    import gsc_pkg::*;

    localparam int C = COORD_BITS;
    localparam int F = POS_FRAC_BITS;

    // Configuration registers.
    logic               mode_reg;
    logic [31:0]        anchor_reg;
    logic [31:0]        far_reg;
    logic [2:0]         count_reg;
    logic [CFG_W-1:0]   stop_reg [STOP_NUM];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            anchor_reg <= '0;
            far_reg    <= '0;
            count_reg  <= '0;
            for (int i = 0; i < STOP_NUM; i++)
            begin
                stop_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MODE:   mode_reg    <= cfg_data[0];
                REG_ANCHOR: anchor_reg  <= cfg_data[31:0];
                REG_FAR:    far_reg     <= cfg_data[31:0];
                REG_COUNT:  count_reg   <= cfg_data[2:0];
                REG_STOP0:  stop_reg[0] <= cfg_data;
                REG_STOP1:  stop_reg[1] <= cfg_data;
                REG_STOP2:  stop_reg[2] <= cfg_data;
                REG_STOP3:  stop_reg[3] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Unpacked configuration fields.
    logic signed [C-1:0]      ax, ay, fx, fy;
    logic [RADIUS_W-1:0]      radius;
    logic signed [DIFF_W-1:0] dx_w, dy_w;

    assign ax     = anchor_reg[C-1:0];
    assign ay     = anchor_reg[16 +: C];
    assign fx     = far_reg[C-1:0];
    assign fy     = far_reg[16 +: C];
    assign radius = far_reg[RADIUS_W-1:0];
    assign dx_w   = {fx[C-1], fx} - {ax[C-1], ax};
    assign dy_w   = {fy[C-1], fy} - {ay[C-1], ay};

    // Squared gradient length and squared radius, kept ready from config.
    logic signed [PROD_W-1:0] dxsq_reg, dysq_reg;
    logic [LEN_W-1:0]         len2_reg;
    logic [RSQ_W-1:0]         rsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dxsq_reg <= '0;
            dysq_reg <= '0;
            len2_reg <= '0;
            rsq_reg  <= '0;
        end
        else
        begin
            dxsq_reg <= dx_w * dx_w;
            dysq_reg <= dy_w * dy_w;
            len2_reg <= LEN_W'(dxsq_reg) + LEN_W'(dysq_reg);
            rsq_reg  <= radius * radius;
        end
    end

    // Global advance: everything moves when the output is free or taken.
    logic en;
    logic col_vld_reg;

    assign en        = !col_vld_reg || col.ready;
    assign pix.ready = en;

    // Stage 1: offset from the anchor.
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] ex1_reg, ey1_reg;
    logic signed [C-1:0]      px, py;

    assign px = pix.pixel_x[C-1:0];
    assign py = pix.pixel_y[C-1:0];

    // Stage 2: products (dot product terms or squared distance terms).
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prx2_reg, pry2_reg;
    logic signed [DIFF_W-1:0] mbx_w, mby_w;

    assign mbx_w = mode_reg ? ex1_reg : dx_w;
    assign mby_w = mode_reg ? ey1_reg : dy_w;

    // Stage 3: sum of the products.
    logic                    v3_reg;
    logic signed [SUM_W-1:0] sum3_reg;

    // Stage 4: classify the item and form the radicand.
    logic                v4_reg;
    sq_tag_t             tag4_reg;
    logic [RAD_W-1:0]    rad4_reg;
    sq_tag_t             tag4_next;
    logic [SUM_W-1:0]    sum_u;

    assign sum_u = sum3_reg;

    always_comb
    begin
        tag4_next.dot  = sum_u[LEN_W-1:0];
        tag4_next.code = T_CALC;
        if (mode_reg)
        begin
            if (sum_u >= SUM_W'(rsq_reg))
            begin
                tag4_next.code = T_ONE;
            end
        end
        else if (sum3_reg <= 0)
        begin
            tag4_next.code = T_ZERO;
        end
        else if (sum_u >= SUM_W'(len2_reg))
        begin
            tag4_next.code = T_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pix.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex1_reg  <= {px[C-1], px} - {ax[C-1], ax};
            ey1_reg  <= {py[C-1], py} - {ay[C-1], ay};
            prx2_reg <= ex1_reg * mbx_w;
            pry2_reg <= ey1_reg * mby_w;
            sum3_reg <= SUM_W'(prx2_reg) + SUM_W'(pry2_reg);
            tag4_reg <= tag4_next;
            rad4_reg <= {sum_u[RSQ_W-1:0], {(2*F){1'b0}}};
        end
    end

    // Square root of the scaled squared distance.
    logic              vs_w;
    logic [ROOT_W-1:0] root_w;
    logic [$bits(sq_tag_t)-1:0] tags_bits;
    sq_tag_t           tags_w;

    gsc_sqrt_pipe #(
        .RB (RAD_W),
        .TW ($bits(sq_tag_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .rad       (rad4_reg),
        .tag_in    (tag4_reg),
        .out_valid (vs_w),
        .root      (root_w),
        .tag_out   (tags_bits)
    );

    assign tags_w = sq_tag_t'(tags_bits);

    // Gradient position divider.
    logic [LEN_W-1:0] tnum_w, tden_w;
    logic             vt_w;
    logic [F-1:0]     tq_w;
    logic [1:0]       tcode_bits;
    tcode_t           tcode_w;

    assign tnum_w = mode_reg ? LEN_W'(root_w) : tags_w.dot;
    assign tden_w = mode_reg ? LEN_W'({radius, {F{1'b0}}}) : len2_reg;

    gsc_div_pipe #(
        .W  (LEN_W),
        .QB (F),
        .TW (2)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vs_w),
        .num       (tnum_w),
        .den       (tden_w),
        .tag_in    (tags_w.code),
        .out_valid (vt_w),
        .quo       (tq_w),
        .tag_out   (tcode_bits)
    );

    assign tcode_w = tcode_t'(tcode_bits);

    // Stop select: find the two stops around the position.
    logic [POS_W-1:0] t_w;
    logic [2:0]       cnt_w;
    logic [1:0]       last_w;
    logic [POS_W-1:0] pos_w [STOP_NUM];
    logic [31:0]      colr_w [STOP_NUM];
    logic             flat_w;
    logic             found_w;
    blend_tag_t       sel_next;
    logic [POS_W-1:0] lnum_next, lden_next;

    always_comb
    begin
        case (tcode_w)
            T_ZERO:  t_w = '0;
            T_ONE:   t_w = ONE_POS;
            default: t_w = POS_W'(tq_w);
        endcase
    end

    assign cnt_w  = (count_reg > STOP_MAX) ? STOP_MAX : count_reg;
    assign last_w = 2'(cnt_w - 3'd1);
    assign flat_w = mode_reg ? (radius == '0) : (len2_reg == '0);

    for (genvar k = 0; k < STOP_NUM; k++) begin : g_stop
        assign pos_w[k]  = stop_reg[k][32 +: POS_W];
        assign colr_w[k] = stop_reg[k][31:0];
    end

    always_comb
    begin
        sel_next.c0 = colr_w[last_w];
        sel_next.c1 = colr_w[last_w];
        lnum_next   = '0;
        lden_next   = POS_W'(1);
        found_w     = 1'b0;
        if (cnt_w == 3'd0)
        begin
            sel_next.c0 = OPAQUE_BLACK;
            sel_next.c1 = OPAQUE_BLACK;
        end
        else if (flat_w || (t_w <= pos_w[0]))
        begin
            sel_next.c0 = colr_w[0];
            sel_next.c1 = colr_w[0];
        end
        else if (t_w < pos_w[last_w])
        begin
            for (int i = 1; i < STOP_NUM; i++)
            begin
                if (!found_w && (2'(i) <= last_w) && (t_w <= pos_w[i]))
                begin
                    found_w = 1'b1;
                    if ((pos_w[i] <= pos_w[i-1]) ||
                        ((t_w - pos_w[i-1]) >= (pos_w[i] - pos_w[i-1])))
                    begin
                        sel_next.c0 = colr_w[i];
                        sel_next.c1 = colr_w[i];
                    end
                    else
                    begin
                        sel_next.c0 = colr_w[i-1];
                        sel_next.c1 = colr_w[i];
                        lnum_next   = t_w - pos_w[i-1];
                        lden_next   = pos_w[i] - pos_w[i-1];
                    end
                end
            end
        end
    end

    logic             vsel_reg;
    blend_tag_t       sel_reg;
    logic [POS_W-1:0] lnum_reg, lden_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsel_reg <= 1'b0;
        end
        else if (en)
        begin
            vsel_reg <= vt_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg  <= sel_next;
            lnum_reg <= lnum_next;
            lden_reg <= lden_next;
        end
    end

    // Blend factor divider.
    logic       vl_w;
    logic [F-1:0] lt_w;
    logic [$bits(blend_tag_t)-1:0] blend_bits;
    blend_tag_t blend_w;

    gsc_div_pipe #(
        .W  (POS_W),
        .QB (F),
        .TW ($bits(blend_tag_t))
    ) u_ldiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vsel_reg),
        .num       (lnum_reg),
        .den       (lden_reg),
        .tag_in    (sel_reg),
        .out_valid (vl_w),
        .quo       (lt_w),
        .tag_out   (blend_bits)
    );

    assign blend_w = blend_tag_t'(blend_bits);

    // Per-channel blend of the two stop colors.
    localparam int BW = 8 + POS_W + 1;

    logic [31:0]      mix_w;
    logic [POS_W-1:0] lt_ext, lt_inv;

    assign lt_ext = POS_W'(lt_w);
    assign lt_inv = ONE_POS - lt_ext;

    always_comb
    begin
        logic [BW-1:0] acc;
        for (int ch = 0; ch < 4; ch++)
        begin
            acc = BW'(blend_w.c0[8*ch +: 8]) * BW'(lt_inv)
                + BW'(blend_w.c1[8*ch +: 8]) * BW'(lt_ext);
            mix_w[8*ch +: 8] = acc[F +: 8];
        end
    end

    // Output register.
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            col_vld_reg <= vl_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= mix_w[23:16];
            green_reg <= mix_w[15:8];
            blue_reg  <= mix_w[7:0];
            alpha_reg <= mix_w[31:24];
        end
    end

    assign col.valid = col_vld_reg;
    assign col.red   = red_reg;
    assign col.green = green_reg;
    assign col.blue  = blue_reg;
    assign col.alpha = alpha_reg;

    // A new result only shows up after the pipe has advanced.
    a_out_after_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(col_vld_reg) |-> $past(en))
        else $error("output became valid without a pipeline advance");

    // A held pipeline keeps its first stage.
    a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg))
        else $error("first stage changed during a stall");

    // An accepted item occupies the first stage next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> v1_reg)
        else $error("accepted item missing from the first stage");

endmodule

// ===== rtl/gsc_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// gsc_sqrt_pipe: pipelined integer square root.
// Restoring digit-by-digit root, one result bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
module gsc_sqrt_pipe #(
    parameter int RB = 56,
    parameter int TW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RB-1:0]      rad,
    input  logic [TW-1:0]      tag_in,
    output logic               out_valid,
    output logic [RB/2-1:0]    root,
    output logic [TW-1:0]      tag_out
);
    localparam int HW  = RB / 2;
    localparam int RMW = HW + 2;

    logic            vld_reg  [HW];
    logic [RB-1:0]   rad_reg  [HW];
    logic [RMW-1:0]  rem_reg  [HW];
    logic [HW-1:0]   root_reg [HW];
    logic [TW-1:0]   tag_reg  [HW];

    for (genvar k = 0; k < HW; k++) begin : g_stage
        logic           vld_prev;
        logic [RB-1:0]  rad_prev;
        logic [RMW-1:0] rem_prev;
        logic [HW-1:0]  root_prev;
        logic [TW-1:0]  tag_prev;
        logic [RMW+1:0] cat;
        logic [RMW+1:0] trial;
        logic           ge;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign rad_prev  = rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign tag_prev  = tag_in;
        end
        else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign tag_prev  = tag_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign cat   = {rem_prev, rad_prev[RB-1 -: 2]};
        assign trial = (RMW+2)'({root_prev, 2'b01});
        assign ge    = (cat >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_prev[RB-3:0], 2'b00};
                rem_reg[k]  <= ge ? RMW'(cat - trial) : RMW'(cat);
                root_reg[k] <= HW'({root_prev, ge});
                tag_reg[k]  <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[HW-1];
    assign root      = root_reg[HW-1];
    assign tag_out   = tag_reg[HW-1];

endmodule

// ===== rtl/gsc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// gsc_div_pipe: pipelined fractional divider.
// Gives floor(num * 2^QB / den) for num below den, one quotient bit per
// stage, with a sideband that travels alongside each item.
// ----------------------------------------------------------------------------
module gsc_div_pipe #(
    parameter int W  = 13,
    parameter int QB = 12,
    parameter int TW = 1
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [W-1:0]   num,
    input  logic [W-1:0]   den,
    input  logic [TW-1:0]  tag_in,
    output logic           out_valid,
    output logic [QB-1:0]  quo,
    output logic [TW-1:0]  tag_out
);
    logic           vld_reg [QB];
    logic [W-1:0]   rem_reg [QB];
    logic [W-1:0]   den_reg [QB];
    logic [QB-1:0]  q_reg   [QB];
    logic [TW-1:0]  tag_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic          vld_prev;
        logic [W-1:0]  rem_prev;
        logic [W-1:0]  den_prev;
        logic [QB-1:0] q_prev;
        logic [TW-1:0] tag_prev;
        logic [W:0]    rem2;
        logic          ge;

        if (k == 0) begin : g_first
            assign vld_prev = in_valid;
            assign rem_prev = num;
            assign den_prev = den;
            assign q_prev   = '0;
            assign tag_prev = tag_in;
        end
        else begin : g_next
            assign vld_prev = vld_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign q_prev   = q_reg[k-1];
            assign tag_prev = tag_reg[k-1];
        end

        // Shift the remainder and subtract the divisor when it fits.
        assign rem2 = {rem_prev, 1'b0};
        assign ge   = (rem2 >= {1'b0, den_prev});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? W'(rem2 - {1'b0, den_prev}) : rem2[W-1:0];
                den_reg[k] <= den_prev;
                q_reg[k]   <= QB'({q_prev, ge});
                tag_reg[k] <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign quo       = q_reg[QB-1];
    assign tag_out   = tag_reg[QB-1];

endmodule
